// ===== design/bcp_pkg.sv =====
// Shared types and constants for the Barrett constant precompute pipeline.
`default_nettype none

package bcp_pkg;

    localparam int MOD_W   = 64;   // input modulus word
    localparam int WORD_W  = 64;   // one word of the quotient
    localparam int QUOT_W  = 128;  // full quotient of 2^128 / m
    localparam int BITS_W  = 6;    // significant bit count field

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_ZERO    = 2'd1,
        ST_INVALID = 2'd2
    } status_t;

    // Sideband that travels with each beat down the divider
    typedef struct packed {
        status_t             status;
        logic [BITS_W-1:0]   bit_count;
    } meta_t;

endpackage

`default_nettype wire

// ===== design/bcp_classify.sv =====
// Front stage: sorts the modulus into ok, zero or invalid and counts its bits.
`default_nettype none

module bcp_classify #(
    parameter int MAX_BITS = 61
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        en,
    input  wire logic                        up_valid,
    input  wire logic [bcp_pkg::MOD_W-1:0]   up_m,
    output logic                             dn_valid,
    output bcp_pkg::meta_t                   dn_meta,
    output logic [MAX_BITS-1:0]              dn_m
);
    import bcp_pkg::*;

    logic                   valid_reg;
    meta_t                  meta_reg;
    meta_t                  meta_next;
    logic [MAX_BITS-1:0]    m_reg;

    function automatic logic [BITS_W-1:0] sig_bits(input logic [MOD_W-1:0] v);
        logic [BITS_W:0] n;
        n = '0;
        for (int i = 0; i < MOD_W; i++) begin
            if (v[i])
            begin
                n = (BITS_W + 1)'(i + 1);
            end
        end
        return n[BITS_W-1:0];
    endfunction

    always_comb
    begin
        meta_next.bit_count = sig_bits(up_m);
        priority if (up_m == '0)
        begin
            meta_next.status = ST_ZERO;
        end
        else if ((up_m[MOD_W-1:MAX_BITS] != '0) || (up_m == MOD_W'(1)))
        begin
            meta_next.status = ST_INVALID;
        end
        else
        begin
            meta_next.status = ST_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            meta_reg <= meta_next;
            m_reg    <= up_m[MAX_BITS-1:0];
        end
    end

    assign dn_valid = valid_reg;
    assign dn_meta  = meta_reg;
    assign dn_m     = m_reg;

endmodule

`default_nettype wire

// ===== design/bcp_div_step.sv =====
// One restoring division step: shift remainder, try subtract, emit a quotient bit.
`default_nettype none

module bcp_div_step #(
    parameter int MAX_BITS = 61
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         en,
    input  wire logic                         up_valid,
    input  wire bcp_pkg::meta_t               up_meta,
    input  wire logic [MAX_BITS-1:0]          up_m,
    input  wire logic [MAX_BITS-1:0]          up_r,
    input  wire logic [bcp_pkg::QUOT_W-1:0]   up_q,
    output logic                              dn_valid,
    output bcp_pkg::meta_t                    dn_meta,
    output logic [MAX_BITS-1:0]               dn_m,
    output logic [MAX_BITS-1:0]               dn_r,
    output logic [bcp_pkg::QUOT_W-1:0]        dn_q
);
    import bcp_pkg::*;

    logic                   valid_reg;
    meta_t                  meta_reg;
    logic [MAX_BITS-1:0]    m_reg;
    logic [MAX_BITS-1:0]    r_reg;
    logic [QUOT_W-1:0]      q_reg;

    logic [MAX_BITS:0]      shifted;
    logic [MAX_BITS+1:0]    diff;
    logic                   take;
    logic [MAX_BITS-1:0]    r_next;
    logic [QUOT_W-1:0]      q_next;

    // Remainder stays below m, so the shifted value fits one extra bit
    always_comb
    begin
        shifted = {up_r, 1'b0};
        diff    = {1'b0, shifted} - {2'b00, up_m};
        take    = !diff[MAX_BITS+1];
        r_next  = take ? diff[MAX_BITS-1:0] : shifted[MAX_BITS-1:0];
        q_next  = {up_q[QUOT_W-2:0], take};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            meta_reg <= up_meta;
            m_reg    <= up_m;
            r_reg    <= r_next;
            q_reg    <= q_next;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_meta  = meta_reg;
    assign dn_m     = m_reg;
    assign dn_r     = r_reg;
    assign dn_q     = q_reg;

endmodule

`default_nettype wire

// ===== design/bcp_out_skid.sv =====
// Result masking, output register and skid register at the tail of the pipeline.
`default_nettype none

module bcp_out_skid #(
    parameter int MAX_BITS = 61
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         tail_valid,
    input  wire bcp_pkg::meta_t               tail_meta,
    input  wire logic [MAX_BITS-1:0]          tail_r,
    input  wire logic [bcp_pkg::QUOT_W-1:0]   tail_q,
    output logic                              advance,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output bcp_pkg::status_t                  status,
    output logic [bcp_pkg::BITS_W-1:0]        bit_count,
    output logic [bcp_pkg::WORD_W-1:0]        ratio_low,
    output logic [bcp_pkg::WORD_W-1:0]        ratio_high,
    output logic [MAX_BITS-1:0]               remainder
);
    import bcp_pkg::*;

    logic                   ok;
    meta_t                  res_meta;
    logic [QUOT_W-1:0]      res_q;
    logic [MAX_BITS-1:0]    res_r;
    logic                   tail_take;
    logic                   out_free;

    logic                   out_valid_reg;
    meta_t                  out_meta_reg;
    logic [QUOT_W-1:0]      out_q_reg;
    logic [MAX_BITS-1:0]    out_r_reg;

    logic                   skid_valid_reg;
    meta_t                  skid_meta_reg;
    logic [QUOT_W-1:0]      skid_q_reg;
    logic [MAX_BITS-1:0]    skid_r_reg;

    // Anything but ok carries only its status
    always_comb
    begin
        ok                 = (tail_meta.status == ST_OK);
        res_meta.status    = tail_meta.status;
        res_meta.bit_count = ok ? tail_meta.bit_count : '0;
        res_q              = ok ? tail_q : '0;
        res_r              = ok ? tail_r : '0;
    end

    // Pipeline moves whenever the skid slot is empty; registered, no ready ripple
    assign advance   = !skid_valid_reg;
    assign tail_take = tail_valid && advance;
    assign out_free  = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg  <= skid_valid_reg || tail_take;
            skid_valid_reg <= 1'b0;
        end
        else if (tail_take)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_meta_reg <= skid_meta_reg;
                out_q_reg    <= skid_q_reg;
                out_r_reg    <= skid_r_reg;
            end
            else
            begin
                out_meta_reg <= res_meta;
                out_q_reg    <= res_q;
                out_r_reg    <= res_r;
            end
        end
        else if (tail_take)
        begin
            skid_meta_reg <= res_meta;
            skid_q_reg    <= res_q;
            skid_r_reg    <= res_r;
        end
    end

    assign out_valid  = out_valid_reg;
    assign status     = out_meta_reg.status;
    assign bit_count  = out_meta_reg.bit_count;
    assign ratio_low  = out_q_reg[WORD_W-1:0];
    assign ratio_high = out_q_reg[QUOT_W-1:WORD_W];
    assign remainder  = out_r_reg;

endmodule

`default_nettype wire

// ===== design/barrett_constant_precompute_unit.sv =====
// Top level of the Barrett constant precompute unit: classify, divider pipeline, output.
`default_nettype none

// Takes one modulus m per beat and returns floor(2^128 / m) as two 64-bit words,
// 2^128 mod m and the significant bit count of m; a zero modulus reports
// ST_ZERO and a modulus of one or wider than MAX_BITS bits reports ST_INVALID,
// all other fields zero. The quotient comes from restoring long division, one
// quotient bit per pipeline stage, 128 stages in all behind a classify stage,
// and a new modulus is accepted every cycle while in_ready is high. The output
// register is backed by a skid register, so in_ready is a flop and only drops
// once a result is held in both.
module barrett_constant_precompute_unit #(
    parameter int MAX_BITS = 61
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [bcp_pkg::MOD_W-1:0]   modulus_value,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output bcp_pkg::status_t                 status,
    output logic [bcp_pkg::BITS_W-1:0]       bit_count,
    output logic [bcp_pkg::WORD_W-1:0]       ratio_low,
    output logic [bcp_pkg::WORD_W-1:0]       ratio_high,
    output logic [MAX_BITS-1:0]              remainder
);
    import bcp_pkg::*;

    localparam int STEPS = QUOT_W;

    logic                   advance;
    logic                   stage_valid [0:STEPS];
    meta_t                  stage_meta  [0:STEPS];
    logic [MAX_BITS-1:0]    stage_m     [0:STEPS];
    logic [MAX_BITS-1:0]    stage_r     [0:STEPS];
    logic [QUOT_W-1:0]      stage_q     [0:STEPS];

    assign in_ready = advance;

    bcp_classify #(
        .MAX_BITS (MAX_BITS)
    ) u_classify (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (advance),
        .up_valid (in_valid),
        .up_m     (modulus_value),
        .dn_valid (stage_valid[0]),
        .dn_meta  (stage_meta[0]),
        .dn_m     (stage_m[0])
    );

    // The leading numerator bit always leaves remainder 1 and quotient bit 0 (m >= 2)
    assign stage_r[0] = MAX_BITS'(1);
    assign stage_q[0] = '0;

    for (genvar k = 0; k < STEPS; k++) begin : g_step
        bcp_div_step #(
            .MAX_BITS (MAX_BITS)
        ) u_step (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (advance),
            .up_valid (stage_valid[k]),
            .up_meta  (stage_meta[k]),
            .up_m     (stage_m[k]),
            .up_r     (stage_r[k]),
            .up_q     (stage_q[k]),
            .dn_valid (stage_valid[k+1]),
            .dn_meta  (stage_meta[k+1]),
            .dn_m     (stage_m[k+1]),
            .dn_r     (stage_r[k+1]),
            .dn_q     (stage_q[k+1])
        );
    end

    bcp_out_skid #(
        .MAX_BITS (MAX_BITS)
    ) u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .tail_valid (stage_valid[STEPS]),
        .tail_meta  (stage_meta[STEPS]),
        .tail_r     (stage_r[STEPS]),
        .tail_q     (stage_q[STEPS]),
        .advance    (advance),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .status     (status),
        .bit_count  (bit_count),
        .ratio_low  (ratio_low),
        .ratio_high (ratio_high),
        .remainder  (remainder)
    );

    // Rejected moduli carry nothing but their status
    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status != ST_OK)) |->
            (bit_count == '0 && ratio_low == '0 && ratio_high == '0 && remainder == '0))
        else $error("rejected modulus with nonzero result fields");

    // A good modulus is at least 2 and below 2^MAX_BITS
    a_ok_range: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status == ST_OK)) |->
            (bit_count >= BITS_W'(2) && bit_count <= BITS_W'(MAX_BITS)
             && ratio_high != '0))
        else $error("ok result out of range");

    // Remainder is below m, hence below 2^bit_count
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status == ST_OK)) |-> ((remainder >> bit_count) == '0))
        else $error("remainder not below modulus");

    // Input stalls only while a result is already parked behind a waiting output
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (out_valid && $past(out_valid) && !$past(out_ready)))
        else $error("input stalled without a held result");

endmodule

`default_nettype wire

// ===== bench/barrett_constant_precompute_unit_tb.sv =====
// Testbench for barrett_constant_precompute_unit: directed table, random moduli, checked beat by beat.
`timescale 1ns / 1ps

module barrett_constant_precompute_unit_tb;
    import bcp_pkg::*;

    localparam int MAX_BITS    = 61;
    localparam int RANDOM_ITEMS = 1630;
    localparam int IDLE_LIMIT  = 3000;   // cycles with no beat on either side
    localparam int LONG_HOLD   = 400;    // well past the pipeline depth
    localparam int DRAIN_WAIT  = 150;    // pipeline latency plus margin

    typedef struct packed {
        status_t               status;
        logic [BITS_W-1:0]     bit_count;
        logic [WORD_W-1:0]     ratio_low;
        logic [WORD_W-1:0]     ratio_high;
        logic [MAX_BITS-1:0]   remainder;
    } barrett_result_t;

    typedef struct packed {
        logic [MOD_W-1:0]  modulus;
        logic              typed;
        barrett_result_t   want;
    } modulus_row_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic [MOD_W-1:0]      modulus_value = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    status_t               status;
    logic [BITS_W-1:0]     bit_count;
    logic [WORD_W-1:0]     ratio_low;
    logic [WORD_W-1:0]     ratio_high;
    logic [MAX_BITS-1:0]   remainder;

    barrett_result_t       constants_q[$];
    modulus_row_t          directed_rows[$];
    logic                  row_typed = 1'b0;
    barrett_result_t       row_want = '0;
    int                    fail_count = 0;
    int                    results_seen = 0;
    int                    idle_cycles = 0;
    bit                    burst_mode = 1'b0;

    barrett_constant_precompute_unit #(
        .MAX_BITS(MAX_BITS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .modulus_value(modulus_value),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .status(status),
        .bit_count(bit_count),
        .ratio_low(ratio_low),
        .ratio_high(ratio_high),
        .remainder(remainder)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Restoring division of 2^128 by m; the leading one never yields a quotient bit for m >= 2
    function automatic barrett_result_t barrett_constants(input logic [MOD_W-1:0] m);
        barrett_result_t res;
        logic [63:0]     r;
        logic [127:0]    q;
        int              i;
        res = '0;
        q = '0;
        r = 64'd1;
        if (m == '0)
            res.status = ST_ZERO;
        else if ((m >> MAX_BITS) != '0 || m == 64'd1)
            res.status = ST_INVALID;
        else
        begin
            for (i = 127; i >= 0; i--)
            begin
                r = {r[62:0], 1'b0};
                if (r >= m)
                begin
                    r = r - m;
                    q[i] = 1'b1;
                end
            end
            res.status = ST_OK;
            for (i = 0; i < MOD_W; i++)
                if (m[i])
                    res.bit_count = BITS_W'(i + 1);
            res.ratio_low = q[63:0];
            res.ratio_high = q[127:64];
            res.remainder = r[MAX_BITS-1:0];
        end
        return res;
    endfunction

    function automatic logic [MOD_W-1:0] random_modulus();
        logic [MOD_W-1:0] v;
        int               w;
        int               pick;
        v = {$urandom, $urandom};
        pick = $urandom_range(0, 99);
        if (pick < 3)
            v = '0;
        else if (pick < 5)
            v = 64'd1;
        else if (pick < 15)
            v = v | (64'd1 << $urandom_range(MAX_BITS, 63));
        else if (pick < 22)
        begin
            // powers of two and their neighbors
            w = $urandom_range(1, MAX_BITS - 1);
            v = (64'd1 << w);
            case ($urandom_range(0, 2))
                0: v = v - 64'd1;
                1: v = v + 64'd1;
                default: ;
            endcase
            if (v < 64'd2)
                v = 64'd2;
        end
        else
        begin
            w = $urandom_range(2, MAX_BITS);
            v = (v & ((64'd1 << w) - 64'd1)) | (64'd1 << (w - 1));
        end
        return v;
    endfunction

    function automatic int random_gap();
        int pick;
        pick = $urandom_range(0, 99);
        if (burst_mode || pick < 55)
            return 0;
        else if (pick < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 60);
    endfunction

    task automatic send_modulus(input logic [MOD_W-1:0] m, input logic typed,
                                input barrett_result_t want);
        @(negedge clk);
        in_valid <= 1'b1;
        modulus_value <= m;
        row_typed = typed;
        row_want = want;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic idle_input(input int gap);
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    // Stop offering and wait until every queued result has come back
    task automatic drain_pipeline();
        idle_input(1);
        while (constants_q.size() != 0)
            @(posedge clk);
    endtask

    // Accept tracking, result checking and the watchdog
    always @(posedge clk)
    begin
        barrett_result_t got;
        barrett_result_t exp_res;
        bit              moved;
        moved = 1'b0;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                moved = 1'b1;
                if (row_typed)
                    constants_q.push_back(row_want);
                else
                    constants_q.push_back(barrett_constants(modulus_value));
            end
            if (out_valid && out_ready)
            begin
                moved = 1'b1;
                results_seen++;
                got = '{status, bit_count, ratio_low, ratio_high, remainder};
                if (constants_q.size() == 0)
                begin
                    $error("unexpected result beat, status %0d", got.status);
                    fail_count++;
                end
                else
                begin
                    exp_res = constants_q.pop_front();
                    if (got.status !== exp_res.status)
                    begin
                        $error("status: expected %0d, got %0d", exp_res.status, got.status);
                        fail_count++;
                    end
                    if (got.bit_count !== exp_res.bit_count)
                    begin
                        $error("bit_count: expected %0d, got %0d",
                               exp_res.bit_count, got.bit_count);
                        fail_count++;
                    end
                    if (got.ratio_low !== exp_res.ratio_low)
                    begin
                        $error("ratio_low: expected %h, got %h",
                               exp_res.ratio_low, got.ratio_low);
                        fail_count++;
                    end
                    if (got.ratio_high !== exp_res.ratio_high)
                    begin
                        $error("ratio_high: expected %h, got %h",
                               exp_res.ratio_high, got.ratio_high);
                        fail_count++;
                    end
                    if (got.remainder !== exp_res.remainder)
                    begin
                        $error("remainder: expected %h, got %h",
                               exp_res.remainder, got.remainder);
                        fail_count++;
                    end
                end
            end
            idle_cycles = moved ? 0 : idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("FAIL");
                $finish;
            end
        end
    end

    // Result side: random ready pattern, one long hold once the run is well underway
    initial
    begin
        int  run_len;
        int  gap;
        int  pick;
        bit  held;
        held = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (!held && results_seen >= 700)
            begin
                held = 1'b1;
                burst_mode = 1'b1;
                @(negedge clk);
                out_ready <= 1'b0;
                repeat (LONG_HOLD - 1) @(negedge clk);
                burst_mode = 1'b0;
            end
            pick = $urandom_range(0, 99);
            run_len = (pick < 8) ? $urandom_range(150, 250) : $urandom_range(1, 30);
            @(negedge clk);
            out_ready <= 1'b1;
            repeat (run_len - 1) @(negedge clk);
            pick = $urandom_range(0, 99);
            if (pick < 30)
                gap = 0;
            else if (pick < 92)
                gap = $urandom_range(1, 3);
            else
                gap = $urandom_range(20, 80);
            if (gap > 0)
            begin
                @(negedge clk);
                out_ready <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
    end

    initial
    begin
        modulus_row_t row;
        int           n;
        // modulus, typed, {status, bit_count, ratio_low, ratio_high, remainder}
        directed_rows.push_back('{64'd0, 1'b1, '{ST_ZERO, 6'd0, 64'd0, 64'd0, 61'd0}});
        directed_rows.push_back('{64'd1, 1'b1, '{ST_INVALID, 6'd0, 64'd0, 64'd0, 61'd0}});
        directed_rows.push_back('{64'd2, 1'b1,
            '{ST_OK, 6'd2, 64'd0, 64'h8000_0000_0000_0000, 61'd0}});
        directed_rows.push_back('{64'd3, 1'b1,
            '{ST_OK, 6'd2, 64'h5555_5555_5555_5555, 64'h5555_5555_5555_5555, 61'd1}});
        directed_rows.push_back('{64'd4, 1'b1,
            '{ST_OK, 6'd3, 64'd0, 64'h4000_0000_0000_0000, 61'd0}});
        directed_rows.push_back('{64'h1000_0000_0000_0000, 1'b1,
            '{ST_OK, 6'd61, 64'd0, 64'h10, 61'd0}});
        directed_rows.push_back('{64'h2000_0000_0000_0000, 1'b1,
            '{ST_INVALID, 6'd0, 64'd0, 64'd0, 61'd0}});
        directed_rows.push_back('{64'h2000_0000_0000_0001, 1'b1,
            '{ST_INVALID, 6'd0, 64'd0, 64'd0, 61'd0}});
        directed_rows.push_back('{64'h8000_0000_0000_0000, 1'b1,
            '{ST_INVALID, 6'd0, 64'd0, 64'd0, 61'd0}});
        directed_rows.push_back('{64'hFFFF_FFFF_FFFF_FFFF, 1'b1,
            '{ST_INVALID, 6'd0, 64'd0, 64'd0, 61'd0}});
        directed_rows.push_back('{64'h5555_5555_5555_5555, 1'b1,
            '{ST_INVALID, 6'd0, 64'd0, 64'd0, 61'd0}});
        directed_rows.push_back('{64'h1FFF_FFFF_FFFF_FFFF, 1'b0, '0});
        directed_rows.push_back('{64'h1555_5555_5555_5555, 1'b0, '0});
        directed_rows.push_back('{64'h0AAA_AAAA_AAAA_AAAA, 1'b0, '0});
        directed_rows.push_back('{64'd5, 1'b0, '0});
        directed_rows.push_back('{64'd7, 1'b0, '0});
        directed_rows.push_back('{64'h0000_0001_0000_0001, 1'b0, '0});
        directed_rows.push_back('{64'h0000_0000_FFFF_FFFF, 1'b0, '0});
        directed_rows.push_back('{64'h1000_0000_0000_0001, 1'b0, '0});
        directed_rows.push_back('{64'h0FFF_FFFF_FFFF_FFFF, 1'b0, '0});

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (directed_rows[i])
        begin
            row = directed_rows[i];
            send_modulus(row.modulus, row.typed, row.want);
            idle_input(random_gap());
        end
        drain_pipeline();

        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            send_modulus(random_modulus(), 1'b0, '0);
            if (n == 1200)
                drain_pipeline();
            else
                idle_input(random_gap());
        end
        drain_pipeline();
        repeat (DRAIN_WAIT) @(posedge clk);

        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
